// ----- sv/ias_pkg.sv -----
// ias_pkg: shared types for the interval activity selection block
// holds the job record layout used by the job store and the control logic
// no dependencies

package ias_pkg;

    // one stored job: tag, start tick and end tick
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] t_start;
        logic [15:0] t_end;
    } job_t;

endpackage

// ----- sv/ias_job_ram.sv -----
// ias_job_ram: job store, one write port and one registered read port
// read data appears in the cycle after the address
// depends on ias_pkg (job_t)

module ias_job_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  ias_pkg::job_t wdata,
    input  logic [AW-1:0] raddr,
    output ias_pkg::job_t rdata
);

    ias_pkg::job_t mem [DEPTH];
    ias_pkg::job_t rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/interval_activity_selection.sv -----
// interval_activity_selection: greedy activity selection by earliest finish
// loads a set of jobs, exchange-sorts them by end time in the job store, then scans
// depends on ias_pkg (job_t) and ias_job_ram
//
//  channel   signals                                       transaction
//  --------  --------------------------------------------  -----------------------------
//  job in    start, busy, job_id, start_time, end_time,    start && !busy at clk edge
//            is_last
//  result    sel_valid, sel_id, sel_start, sel_end,        sel_valid high for one cycle
//            sel_last
//
// a job without is_last is taken when presented and busy stays low.
// closing a set of stored jobs keeps busy high through the exchange sort and the scan:
// one compare per cycle in the exchange sort, bounded by the single read and write port
// of the job store, then one job per cycle in the scan. results come out during the scan,
// the last one in the cycle busy falls.
// reset clears the control state; the job store needs no clearing.
// the receiver cannot stall: each result is presented for exactly one cycle.

module interval_activity_selection #(
    parameter int MAX_JOBS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] job_id,
    input  logic [15:0] start_time,
    input  logic [15:0] end_time,
    input  logic        is_last,
    output logic        sel_valid,
    output logic [15:0] sel_id,
    output logic [15:0] sel_start,
    output logic [15:0] sel_end,
    output logic        sel_last
);

    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    // controller states
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PRD  = 3'd1;
    localparam logic [2:0] S_PLD  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_PEND = 3'd4;
    localparam logic [2:0] S_SST  = 3'd5;
    localparam logic [2:0] S_SRUN = 3'd6;
    localparam logic [2:0] S_SFIN = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic [CW-1:0] b_inc;
    ias_pkg::job_t holder_reg, holder_next;
    ias_pkg::job_t pend_reg, pend_next;
    logic          pend_vld_reg, pend_vld_next;
    logic          sel_valid_reg, sel_valid_next;
    ias_pkg::job_t sel_job_reg, sel_job_next;
    logic          sel_last_reg, sel_last_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    ias_pkg::job_t ram_wdata;
    logic [AW-1:0] ram_raddr;
    ias_pkg::job_t ram_rdata;
    ias_pkg::job_t in_job;

    assign in_job.id      = job_id;
    assign in_job.t_start = start_time;
    assign in_job.t_end   = end_time;
    assign b_inc          = b_reg + CW'(1);

    ias_job_ram #(
        .DEPTH (MAX_JOBS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer: load, exchange sort in memory, greedy scan
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        holder_next    = holder_reg;
        pend_next      = pend_reg;
        pend_vld_next  = pend_vld_reg;
        sel_valid_next = 1'b0;
        sel_job_next   = sel_job_reg;
        sel_last_next  = sel_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = in_job;
        ram_raddr      = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    // store the job unless the store is full
                    if (count_reg < CW'(MAX_JOBS))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (is_last)
                    begin
                        a_next = '0;
                        if (count_next > CW'(1))
                        begin
                            state_next = S_PRD;
                        end
                        else
                        begin
                            state_next = S_SST;
                        end
                    end
                end
            end

            S_PRD:
            begin
                // fetch entry a for this pass
                ram_raddr  = a_reg[AW-1:0];
                b_next     = a_reg + CW'(1);
                state_next = S_PLD;
            end

            S_PLD:
            begin
                holder_next = ram_rdata;
                ram_raddr   = b_reg[AW-1:0];
                state_next  = S_CMP;
            end

            S_CMP:
            begin
                // exchange when the held entry ends later than entry b
                if (holder_reg.t_end > ram_rdata.t_end)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = b_reg[AW-1:0];
                    ram_wdata   = holder_reg;
                    holder_next = ram_rdata;
                end
                if (b_inc < count_reg)
                begin
                    ram_raddr = b_inc[AW-1:0];
                    b_next    = b_inc;
                end
                else
                begin
                    state_next = S_PEND;
                end
            end

            S_PEND:
            begin
                // write back the minimum of the pass
                ram_we    = 1'b1;
                ram_waddr = a_reg[AW-1:0];
                ram_wdata = holder_reg;
                a_next    = a_reg + CW'(1);
                if (a_reg + CW'(2) < count_reg)
                begin
                    state_next = S_PRD;
                end
                else
                begin
                    state_next = S_SST;
                end
            end

            S_SST:
            begin
                ram_raddr     = '0;
                b_next        = '0;
                pend_vld_next = 1'b0;
                state_next    = S_SRUN;
            end

            S_SRUN:
            begin
                // greedy pick; the previous pick goes out once a later one exists
                if (!pend_vld_reg || (ram_rdata.t_start >= pend_reg.t_end))
                begin
                    if (pend_vld_reg)
                    begin
                        sel_valid_next = 1'b1;
                        sel_job_next   = pend_reg;
                        sel_last_next  = 1'b0;
                    end
                    pend_next     = ram_rdata;
                    pend_vld_next = 1'b1;
                end
                if (b_inc < count_reg)
                begin
                    ram_raddr = b_inc[AW-1:0];
                    b_next    = b_inc;
                end
                else
                begin
                    state_next = S_SFIN;
                end
            end

            S_SFIN:
            begin
                // final pick closes the set
                sel_valid_next = 1'b1;
                sel_job_next   = pend_reg;
                sel_last_next  = 1'b1;
                count_next     = '0;
                pend_vld_next  = 1'b0;
                state_next     = S_LOAD;
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            pend_vld_reg  <= 1'b0;
            sel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            pend_vld_reg  <= pend_vld_next;
            sel_valid_reg <= sel_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        holder_reg   <= holder_next;
        pend_reg     <= pend_next;
        sel_job_reg  <= sel_job_next;
        sel_last_reg <= sel_last_next;
    end

    assign busy      = (state_reg != S_LOAD);
    assign sel_valid = sel_valid_reg;
    assign sel_id    = sel_job_reg.id;
    assign sel_start = sel_job_reg.t_start;
    assign sel_end   = sel_job_reg.t_end;
    assign sel_last  = sel_last_reg;

    // the stored job count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_JOBS))
        else $error("job count above capacity");

    // a sort exchange never writes the entry being fetched
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == S_CMP)) |-> (ram_waddr != ram_raddr))
        else $error("job store read and write collide");

    // closing a set makes the block busy
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_last) |=> busy)
        else $error("set closed without processing");

    // the final result of a set is not followed by another in the next cycle
    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_valid && sel_last) |=> !sel_valid)
        else $error("result after final selection");

    // the scan emits only once a pending pick exists
    a_emit_pend: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SRUN) && sel_valid_next) |-> pend_vld_reg)
        else $error("result without pending selection");

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for interval_activity_selection
// drives job sets over the start/busy port and checks each selected job in order
// depends on ias_pkg (job_t) and the interval_activity_selection rtl
`timescale 1ns / 100ps

module tb_top;

    localparam int JOB_SLOTS       = 64;
    localparam int DRAIN_CYCLES    = 2400;    // close of a full store: sort plus scan
    localparam int ITEMS_PER_PHASE = 25;
    localparam int NUM_PHASES      = 4;

    // one selected job as it should appear on the result ports
    typedef struct {
        logic [15:0] id;
        logic [15:0] t_start;
        logic [15:0] t_end;
        logic        last;
    } pick_t;

    // keeps the open job set, and on close predicts the greedy selection
    class activity_scoreboard;
        ias_pkg::job_t open_set[$];
        pick_t         picks[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return picks.size();
        endfunction

        function void note_job(logic [15:0] id, logic [15:0] t_start,
                               logic [15:0] t_end, logic last);
            ias_pkg::job_t tmp;
            ias_pkg::job_t js[$];
            pick_t         chosen[$];
            logic [15:0]   last_end;
            bit            have_pick;
            // jobs beyond capacity are dropped, the close still counts
            if (open_set.size() < JOB_SLOTS)
                open_set.push_back('{id, t_start, t_end});
            if (last) begin
                js = open_set;
                // exchange sort by end time, same pair order as the hardware
                for (int a = 0; a < js.size(); a++) begin
                    for (int b = a + 1; b < js.size(); b++) begin
                        if (js[a].t_end > js[b].t_end) begin
                            tmp   = js[a];
                            js[a] = js[b];
                            js[b] = tmp;
                        end
                    end
                end
                // greedy scan, touching intervals are compatible
                have_pick = 1'b0;
                last_end  = '0;
                foreach (js[k]) begin
                    if (!have_pick || js[k].t_start >= last_end) begin
                        chosen.push_back('{js[k].id, js[k].t_start, js[k].t_end, 1'b0});
                        have_pick = 1'b1;
                        last_end  = js[k].t_end;
                    end
                end
                chosen[chosen.size() - 1].last = 1'b1;
                foreach (chosen[k])
                    picks.push_back(chosen[k]);
                open_set.delete();
            end
        endfunction

        function void check_result(logic [15:0] id, logic [15:0] t_start,
                                   logic [15:0] t_end, logic last);
            pick_t want;
            if (picks.size() == 0) begin
                $error("unexpected result: sel_id %h sel_start %h sel_end %h",
                       id, t_start, t_end);
                errors++;
            end
            else begin
                want = picks.pop_front();
                if (id !== want.id) begin
                    $error("sel_id expected %h got %h", want.id, id);
                    errors++;
                end
                if (t_start !== want.t_start) begin
                    $error("sel_start expected %h got %h", want.t_start, t_start);
                    errors++;
                end
                if (t_end !== want.t_end) begin
                    $error("sel_end expected %h got %h", want.t_end, t_end);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("sel_last expected %b got %b", want.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [15:0] job_id     = '0;
    logic [15:0] start_time = '0;
    logic [15:0] end_time   = '0;
    logic        is_last    = 1'b0;
    logic        busy;
    logic        sel_valid;
    logic [15:0] sel_id;
    logic [15:0] sel_start;
    logic [15:0] sel_end;
    logic        sel_last;

    activity_scoreboard sb;

    interval_activity_selection #(
        .MAX_JOBS (JOB_SLOTS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .job_id     (job_id),
        .start_time (start_time),
        .end_time   (end_time),
        .is_last    (is_last),
        .sel_valid  (sel_valid),
        .sel_id     (sel_id),
        .sel_start  (sel_start),
        .sel_end    (sel_end),
        .sel_last   (sel_last)
    );

    always #5 clk = ~clk;

    // result monitor: every strobed result is one transaction
    always @(posedge clk)
    begin
        if (rst_n && sel_valid)
            sb.check_result(sel_id, sel_start, sel_end, sel_last);
    end

    // present one job and hold it until the block takes it
    task automatic send_job(input logic [15:0] id, input logic [15:0] t_start,
                            input logic [15:0] t_end, input logic last);
        start      <= 1'b1;
        job_id     <= id;
        start_time <= t_start;
        end_time   <= t_end;
        is_last    <= last;
        do @(posedge clk); while (busy);
        sb.note_job(id, t_start, t_end, last);
    endtask

    // sender gap: start held low for the given number of cycles
    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold off until every predicted selection has come out
    task automatic wait_all_results();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one job set with clustered times so ties, overlaps and touching ends are common
    task automatic run_set(input int size, input int idle_pct);
        logic [15:0] base;
        logic [15:0] t_start;
        logic [15:0] t_end;
        base = 16'($urandom_range(0, 65400));
        for (int k = 0; k < size; k++) begin
            if ($urandom_range(3) == 0) begin
                t_start = 16'($urandom);
                t_end   = 16'($urandom);
            end
            else begin
                t_start = base + 16'($urandom_range(0, 40));
                if ($urandom_range(9) == 0)
                    t_end = t_start - 16'($urandom_range(1, 5));
                else
                    t_end = t_start + 16'($urandom_range(0, 15));
            end
            send_job(16'($urandom), t_start, t_end, k == size - 1);
            if ($urandom_range(99) < idle_pct) begin
                if ($urandom_range(7) == 0)
                    pause_sender($urandom_range(10, 60));
                else
                    pause_sender($urandom_range(1, 4));
            end
        end
    endtask

    initial
    begin
        int idle_pct[NUM_PHASES];
        int sent;
        int size;
        idle_pct = '{0, 66, 0, 17};
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-job sets at both extremes of every field
        send_job(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // touching, overlapping, tied ends and a job that starts after its end
        send_job(16'h0001, 16'd3, 16'd8, 1'b0);
        send_job(16'h0002, 16'd0, 16'd5, 1'b0);
        send_job(16'h0003, 16'd5, 16'd8, 1'b0);
        send_job(16'h0004, 16'd8, 16'd8, 1'b0);
        send_job(16'h0005, 16'd9, 16'd2, 1'b0);
        send_job(16'h0006, 16'd7, 16'd12, 1'b1);
        // all ends equal: tie order decides which one wins
        send_job(16'hA5A5, 16'd2, 16'd9, 1'b0);
        send_job(16'h5A5A, 16'd1, 16'd9, 1'b0);
        send_job(16'h00C3, 16'd9, 16'd9, 1'b1);
        // full span job against one at the top tick
        send_job(16'h1234, 16'h0000, 16'hFFFF, 1'b0);
        send_job(16'h8000, 16'hFFFF, 16'hFFFF, 1'b0);
        send_job(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
        wait_all_results();

        // random sets, one idle profile per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (ph == 1 && sent == 0)
                    size = JOB_SLOTS + 2;    // overflow, closing job is dropped
                else if ($urandom_range(15) == 0)
                    size = $urandom_range(40, 70);
                else
                    size = $urandom_range(1, 10);
                run_set(size, idle_pct[ph]);
                sent += size;
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- interval_activity_selection.f -----
sv/ias_pkg.sv
sv/ias_job_ram.sv
sv/interval_activity_selection.sv
bench/tb_top.sv
